@@ hw/rtl/thrt_pkg.sv @@
package thrt_pkg;

    // Default width of the resistance input.
    localparam int RES_BITS_DEF = 24;

    // Number of squaring cells in the log chain (fraction bits of log2).
    localparam int LOG_STEPS = 28;

    // Number of quotient bits produced by the divider chain.
    localparam int DIV_STEPS = 17;

    // ln 2 in Q30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Saturation limits of the Horner accumulator, +-(2^62 - 1).
    localparam logic signed [63:0] ACC_POS = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_NEG = 64'shC000_0000_0000_0001;

    // 100 * 2^40, the numerator of the reciprocal in centi-kelvin.
    localparam logic [62:0] CENTI_ONE_Q40 = 63'd109951162777600;

    // Offset from kelvin to Celsius and the output limits, in 0.01 degree.
    localparam logic signed [17:0] ZERO_C_CENTI = 18'sd27315;
    localparam logic signed [17:0] TEMP_MAX     = 18'sd32767;
    localparam logic signed [17:0] TEMP_MIN     = -18'sd27315;

    // Coefficient reset values.
    localparam logic signed [31:0] A0_RESET = 32'sd497421779;
    localparam logic signed [31:0] A1_RESET = 32'sd432627316;
    localparam logic signed [31:0] A2_RESET = -32'sd8402833;
    localparam logic signed [31:0] A3_RESET = 32'sd445145;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_A0 = 2'd0,
        REG_A1 = 2'd1,
        REG_A2 = 2'd2,
        REG_A3 = 2'd3
    } t_reg_idx;

    // Control flags that travel with each item down the chain.
    typedef struct packed {
        logic valid;
        logic bad;
        logic ovf;
    } t_ctl;

endpackage

@@ hw/rtl/thrt_norm.sv @@
module thrt_norm #(
    parameter int RESISTANCE_BITS = thrt_pkg::RES_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [RESISTANCE_BITS-1:0] i_res,
    output thrt_pkg::t_ctl             o_ctl,
    output logic [31:0]                o_mant,
    output logic [4:0]                 o_exp
);

    logic [4:0]  top_bit;
    logic [31:0] res_ext;

    // Find the top set bit; the last hit in the scan is the highest one.
    always_comb begin
        top_bit = 5'd0;
        for (int k = 0; k < RESISTANCE_BITS; k++) begin
            if (i_res[k]) begin
                top_bit = 5'(k);
            end
        end
        res_ext = 32'(i_res);
    end

    // Register the mantissa, aligned so that the top bit lands at bit 31.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl.valid <= i_valid;
            o_ctl.bad   <= (i_res == '0);
            o_ctl.ovf   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mant <= res_ext << (5'd31 - top_bit);
            o_exp  <= top_bit;
        end
    end

endmodule

@@ hw/rtl/thrt_log_cell.sv @@
module thrt_log_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  thrt_pkg::t_ctl                     i_ctl,
    input  logic [31:0]                        i_mant,
    input  logic [thrt_pkg::LOG_STEPS-1:0]     i_frac,
    input  logic [4:0]                         i_exp,
    output thrt_pkg::t_ctl                     o_ctl,
    output logic [31:0]                        o_mant,
    output logic [thrt_pkg::LOG_STEPS-1:0]     o_frac,
    output logic [4:0]                         o_exp
);

    logic [63:0] square;
    logic [32:0] scaled;

    // Square the Q31 mantissa; a result of 2.0 or more yields a one bit.
    always_comb begin
        square = 64'(i_mant) * 64'(i_mant);
        scaled = square[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mant <= scaled[32] ? scaled[32:1] : scaled[31:0];
            o_frac <= {i_frac[thrt_pkg::LOG_STEPS-2:0], scaled[32]};
            o_exp  <= i_exp;
        end
    end

endmodule

@@ hw/rtl/thrt_horner_step.sv @@
module thrt_horner_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  thrt_pkg::t_ctl      i_ctl,
    input  logic signed [63:0]  i_acc,
    input  logic [32:0]         i_x,
    input  logic signed [31:0]  i_coef,
    output thrt_pkg::t_ctl      o_ctl,
    output logic signed [63:0]  o_acc,
    output logic [32:0]         o_x
);

    thrt_pkg::t_ctl     r_ctl1, r_ctl2, r_ctl3;
    logic [61:0]        r_mag1, r_mag3;
    logic               r_neg1, r_neg2, r_neg3;
    logic [32:0]        r_x1, r_x2, r_x3;
    logic [63:0]        r_plo, r_phi;

    logic [63:0]        abs_acc;
    logic [94:0]        full;
    logic [66:0]        shifted;
    logic signed [63:0] signed_mag;
    logic signed [63:0] sum;

    always_comb begin
        abs_acc    = i_acc[63] ? 64'(-i_acc) : 64'(i_acc);
        full       = {r_phi, 31'd0} + {31'd0, r_plo};
        shifted    = full[94:28];
        signed_mag = r_neg3 ? -$signed({2'b00, r_mag3}) : $signed({2'b00, r_mag3});
        sum        = signed_mag + $signed({{32{i_coef[31]}}, i_coef});
    end

    // Control flags for the four stages of one Horner step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            o_ctl  <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            o_ctl  <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Sign and magnitude of the accumulator.
            r_mag1 <= abs_acc[61:0];
            r_neg1 <= i_acc[63];
            r_x1   <= i_x;
            // Two partial products of the magnitude with ln r.
            r_plo  <= 64'(r_mag1[30:0]) * 64'(r_x1);
            r_phi  <= 64'(r_mag1[61:31]) * 64'(r_x1);
            r_neg2 <= r_neg1;
            r_x2   <= r_x1;
            // Combine, drop 28 fraction bits and saturate the magnitude.
            r_mag3 <= (shifted[66:62] != '0) ? {62{1'b1}} : shifted[61:0];
            r_neg3 <= r_neg2;
            r_x3   <= r_x2;
            // Restore the sign, add the coefficient and clamp.
            if (sum > thrt_pkg::ACC_POS) begin
                o_acc <= thrt_pkg::ACC_POS;
            end else if (sum < thrt_pkg::ACC_NEG) begin
                o_acc <= thrt_pkg::ACC_NEG;
            end else begin
                o_acc <= sum;
            end
            o_x <= r_x3;
        end
    end

endmodule

@@ hw/rtl/thrt_div_cell.sv @@
module thrt_div_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  thrt_pkg::t_ctl                     i_ctl,
    input  logic [62:0]                        i_rem,
    input  logic [78:0]                        i_div,
    input  logic [thrt_pkg::DIV_STEPS-1:0]     i_quo,
    output thrt_pkg::t_ctl                     o_ctl,
    output logic [62:0]                        o_rem,
    output logic [78:0]                        o_div,
    output logic [thrt_pkg::DIV_STEPS-1:0]     o_quo
);

    logic        fits;
    logic [78:0] diff;

    // One restoring step: subtract the shifted divisor where it fits.
    always_comb begin
        diff = {16'd0, i_rem} - i_div;
        fits = ({16'd0, i_rem} >= i_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= fits ? diff[62:0] : i_rem;
            o_div <= {1'b0, i_div[78:1]};
            o_quo <= {i_quo[thrt_pkg::DIV_STEPS-2:0], fits};
        end
    end

endmodule

@@ hw/rtl/thermistor_resistance_to_temp_unit.sv @@
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_resistance_ohms
// output    o_out_valid   i_out_stall   o_temp_centi_c, o_saturated, o_invalid
// config    psel/penable  pready        paddr, pwdata, prdata
//
// One item is taken per cycle while o_in_stall is low; each result is offered once
// it has passed 61 register stages from its input transfer. These are the 28 squaring
// cells of the log, 12 Horner stages and 17 divider cells, plus the normalize, ln,
// divider setup and output stages.
// Reset is synchronous and active low; it clears all valid flags and loads the
// coefficient reset values. A two-entry output buffer catches the item that emerges
// while the output stalls; the chain and the input then stall until it drains.
module thermistor_resistance_to_temp_unit #(
    parameter int RESISTANCE_BITS = thrt_pkg::RES_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [RESISTANCE_BITS-1:0]  i_resistance_ohms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [15:0]          o_temp_centi_c,
    output logic                        o_saturated,
    output logic                        o_invalid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int LS = thrt_pkg::LOG_STEPS;
    localparam int DS = thrt_pkg::DIV_STEPS;

    logic signed [31:0] r_a0, r_a1, r_a2, r_a3;
    thrt_pkg::t_reg_idx reg_idx;
    logic               en;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = thrt_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0 <= thrt_pkg::A0_RESET;
            r_a1 <= thrt_pkg::A1_RESET;
            r_a2 <= thrt_pkg::A2_RESET;
            r_a3 <= thrt_pkg::A3_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                thrt_pkg::REG_A0: r_a0 <= pwdata;
                thrt_pkg::REG_A1: r_a1 <= pwdata;
                thrt_pkg::REG_A2: r_a2 <= pwdata;
                thrt_pkg::REG_A3: r_a3 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            thrt_pkg::REG_A0: prdata = r_a0;
            thrt_pkg::REG_A1: prdata = r_a1;
            thrt_pkg::REG_A2: prdata = r_a2;
            thrt_pkg::REG_A3: prdata = r_a3;
            default:          prdata = '0;
        endcase
    end

    // Normalize the resistance to a Q31 mantissa and an exponent.
    thrt_pkg::t_ctl lg_ctl  [0:LS];
    logic [31:0]    lg_mant [0:LS];
    logic [LS-1:0]  lg_frac [0:LS];
    logic [4:0]     lg_exp  [0:LS];

    assign lg_frac[0] = '0;

    thrt_norm #(
        .RESISTANCE_BITS(RESISTANCE_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_res   (i_resistance_ohms),
        .o_ctl   (lg_ctl[0]),
        .o_mant  (lg_mant[0]),
        .o_exp   (lg_exp[0])
    );

    // Chain of squaring cells, one fraction bit of log2 per cell.
    for (genvar g = 0; g < LS; g++) begin : g_log
        thrt_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (lg_ctl[g]),
            .i_mant  (lg_mant[g]),
            .i_frac  (lg_frac[g]),
            .i_exp   (lg_exp[g]),
            .o_ctl   (lg_ctl[g+1]),
            .o_mant  (lg_mant[g+1]),
            .o_frac  (lg_frac[g+1]),
            .o_exp   (lg_exp[g+1])
        );
    end

    // Scale log2 by ln 2 to get ln r in Q28.
    thrt_pkg::t_ctl     hn_ctl [0:3];
    logic signed [63:0] hn_acc [0:3];
    logic [32:0]        hn_x   [0:3];
    logic signed [31:0] hn_coef [0:2];
    logic [62:0]        ln_prod;
    logic [32:0]        r_ln_x;
    thrt_pkg::t_ctl     r_ln_ctl;

    assign ln_prod = 63'({lg_exp[LS], lg_frac[LS]}) * 63'(thrt_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_ctl <= '0;
        end else if (en) begin
            r_ln_ctl <= lg_ctl[LS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ln_x <= ln_prod[62:30];
        end
    end

    // Horner's rule, starting from the cube coefficient.
    assign hn_ctl[0]  = r_ln_ctl;
    assign hn_acc[0]  = {{32{r_a3[31]}}, r_a3};
    assign hn_x[0]    = r_ln_x;
    assign hn_coef[0] = r_a2;
    assign hn_coef[1] = r_a1;
    assign hn_coef[2] = r_a0;

    for (genvar h = 0; h < 3; h++) begin : g_horner
        thrt_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (hn_ctl[h]),
            .i_acc   (hn_acc[h]),
            .i_x     (hn_x[h]),
            .i_coef  (hn_coef[h]),
            .o_ctl   (hn_ctl[h+1]),
            .o_acc   (hn_acc[h+1]),
            .o_x     (hn_x[h+1])
        );
    end

    // Divider setup: numerator with half the divisor added for rounding,
    // and a check that the quotient fits in the divider's bits.
    thrt_pkg::t_ctl dv_ctl [0:DS];
    logic [62:0]    dv_rem [0:DS];
    logic [78:0]    dv_div [0:DS];
    logic [DS-1:0]  dv_quo [0:DS];
    logic [62:0]    acc_pos;
    logic [62:0]    numer;
    logic           acc_bad;

    always_comb begin
        acc_pos = hn_acc[3][62:0];
        numer   = thrt_pkg::CENTI_ONE_Q40 + {1'b0, acc_pos[62:1]};
        acc_bad = hn_acc[3][63] || (hn_acc[3] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_ctl[0] <= '0;
        end else if (en) begin
            dv_ctl[0].valid <= hn_ctl[3].valid;
            dv_ctl[0].bad   <= hn_ctl[3].bad || acc_bad;
            dv_ctl[0].ovf   <= ({17'd0, numer} >= {acc_pos, 17'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_rem[0] <= numer;
            dv_div[0] <= {acc_pos, 16'd0};
            dv_quo[0] <= '0;
        end
    end

    // Chain of restoring divider cells, one quotient bit per cell.
    for (genvar d = 0; d < DS; d++) begin : g_div
        thrt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (dv_ctl[d]),
            .i_rem   (dv_rem[d]),
            .i_div   (dv_div[d]),
            .i_quo   (dv_quo[d]),
            .o_ctl   (dv_ctl[d+1]),
            .o_rem   (dv_rem[d+1]),
            .o_div   (dv_div[d+1]),
            .o_quo   (dv_quo[d+1])
        );
    end

    // Convert to Celsius and clamp.
    logic signed [17:0] celsius;
    logic signed [15:0] res_temp;
    logic               res_sat;
    logic               res_inv;

    always_comb begin
        celsius = $signed({1'b0, dv_quo[DS]}) - thrt_pkg::ZERO_C_CENTI;
        res_inv = dv_ctl[DS].bad;
        res_sat = 1'b0;
        if (dv_ctl[DS].bad) begin
            res_temp = '0;
        end else if (dv_ctl[DS].ovf || (celsius > thrt_pkg::TEMP_MAX)) begin
            res_temp = 16'(thrt_pkg::TEMP_MAX);
            res_sat  = 1'b1;
        end else if (celsius < thrt_pkg::TEMP_MIN) begin
            res_temp = 16'(thrt_pkg::TEMP_MIN);
            res_sat  = 1'b1;
        end else begin
            res_temp = celsius[15:0];
        end
    end

    // Output register with a skid entry; the chain runs while the skid is empty.
    logic               r_skid_valid;
    logic signed [15:0] r_skid_temp;
    logic               r_skid_sat;
    logic               r_skid_inv;
    logic               out_free;
    logic               emerge;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign out_free   = !o_out_valid || !i_out_stall;
    assign emerge     = en && dv_ctl[DS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                o_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (emerge) begin
            if (out_free) begin
                o_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                o_temp_centi_c <= r_skid_temp;
                o_saturated    <= r_skid_sat;
                o_invalid      <= r_skid_inv;
            end
        end else if (emerge) begin
            if (out_free) begin
                o_temp_centi_c <= res_temp;
                o_saturated    <= res_sat;
                o_invalid      <= res_inv;
            end else begin
                r_skid_temp <= res_temp;
                r_skid_sat  <= res_sat;
                r_skid_inv  <= res_inv;
            end
        end
    end

endmodule
